FILE: rtl/k_weighting_filter_macros.svh
// Assertion macros for the K-weighting filter.
// Included by the top level; needs the clock and reset ports in scope.
`ifndef K_WEIGHTING_FILTER_MACROS_SVH
`define K_WEIGHTING_FILTER_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define KWF_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("kwf assertion failed");

// Next-cycle implication.
`define KWF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("kwf assertion failed");

`endif

FILE: rtl/kwf_pkg.sv
// Shared types and constants for the K-weighting filter.
// No dependencies; imported by every module of the block.
package kwf_pkg;

   localparam int CHANNELS  = 5;
   localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CH_W      = 3;
   localparam int SAMPLE_W  = 24;
   localparam int HIST_W    = 28;
   localparam int COEF_W    = 32;
   localparam int OPND_W    = HIST_W + 1;
   localparam int PROD_W    = COEF_W + OPND_W;
   localparam int ACC_W     = 64;
   localparam int FRAC_DROP = 28;
   localparam int NUM_REGS  = 8;
   localparam int REG_IDX_W = 3;
   localparam int STEPS     = 5;
   localparam int STEP_W    = 3;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_SHELF_B0      = 3'd0,
      REG_SHELF_B1      = 3'd1,
      REG_SHELF_B2      = 3'd2,
      REG_SHELF_A1      = 3'd3,
      REG_SHELF_A2      = 3'd4,
      REG_HIGHPASS_GAIN = 3'd5,
      REG_HIGHPASS_A1   = 3'd6,
      REG_HIGHPASS_A2   = 3'd7
   } reg_index_type;

   // 48 kHz coefficient set, signed Q4.28.
   localparam logic signed [COEF_W-1:0] REG_RESET [NUM_REGS] = '{
      32'sd412081942, -32'sd722546695, 32'sd321691122, -32'sd453832898,
      32'sd196623811, 32'sd268435456, -32'sd534199295, 32'sd265770495
   };

   typedef struct packed {
      logic                       func;
      logic [CH_W-1:0]            channel;
      logic signed [SAMPLE_W-1:0] sample;
   } req_type;

   typedef struct packed {
      logic [CH_W-1:0]          out_channel;
      logic signed [HIST_W-1:0] weighted;
   } rsp_type;

   // Controller to datapath.
   typedef struct packed {
      logic              load;
      logic              acc_clr;
      logic              mul_en;
      logic              hp_stage;
      logic [STEP_W-1:0] step;
      logic              shelf_rnd;
      logic              hp_rnd;
      logic              retire;
   } kwf_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic bypass;
   } kwf_status_type;

endpackage

FILE: rtl/kwf_ctrl.sv
// Sequencer for the K-weighting filter: steps the shared multiplier through
// both biquad stages and owns the handshakes. Depends on kwf_pkg.
module kwf_ctrl
   import kwf_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   input  kwf_status_type status,
   output kwf_cmd_type    cmd
);

   typedef enum logic [7:0] {
      ST_IDLE      = 8'b0000_0001,
      ST_MAC_SHELF = 8'b0000_0010,
      ST_END_SHELF = 8'b0000_0100,
      ST_RND_SHELF = 8'b0000_1000,
      ST_MAC_HP    = 8'b0001_0000,
      ST_END_HP    = 8'b0010_0000,
      ST_RND_HP    = 8'b0100_0000,
      ST_FINISH    = 8'b1000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              last_step;
   logic              out_free;

   assign last_step = (step_ff == STEP_W'(STEPS - 1));
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_MAC_SHELF;
         end
         ST_MAC_SHELF: begin
            if (status.bypass) state_in = ST_FINISH;
            else if (last_step) state_in = ST_END_SHELF;
         end
         ST_END_SHELF: state_in = ST_RND_SHELF;
         ST_RND_SHELF: state_in = ST_MAC_HP;
         ST_MAC_HP: begin
            if (last_step) state_in = ST_END_HP;
         end
         ST_END_HP: state_in = ST_RND_HP;
         ST_RND_HP: state_in = ST_FINISH;
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      step_in = '0;
      if ((state_ff == ST_MAC_SHELF && !status.bypass) || state_ff == ST_MAC_HP) begin
         step_in = last_step ? '0 : step_ff + STEP_W'(1);
      end
   end

   always_comb begin
      cmd           = '0;
      cmd.load      = (state_ff == ST_IDLE) && req_valid;
      cmd.acc_clr   = cmd.load || (state_ff == ST_RND_SHELF);
      cmd.mul_en    = (state_ff == ST_MAC_SHELF && !status.bypass) || (state_ff == ST_MAC_HP);
      cmd.hp_stage  = (state_ff == ST_MAC_HP);
      cmd.step      = step_ff;
      cmd.shelf_rnd = (state_ff == ST_RND_SHELF);
      cmd.hp_rnd    = (state_ff == ST_RND_HP);
      cmd.retire    = (state_ff == ST_FINISH) && out_free;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.retire) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: rtl/kwf_dp.sv
// Datapath of the K-weighting filter: coefficient registers, per-channel
// delay state, one shared multiplier and the accumulator. Depends on kwf_pkg.
module kwf_dp
   import kwf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  req_type              req_data,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [REG_IDX_W-1:0] csr_index,
   input  logic [COEF_W-1:0]    csr_wdata,
   input  kwf_cmd_type          cmd,
   output kwf_status_type       status
);

   logic signed [COEF_W-1:0]   coef_ff [NUM_REGS];
   logic signed [SAMPLE_W-1:0] xh_ff [CHANNELS][2];
   logic signed [HIST_W-1:0]   sh_ff [CHANNELS][2];
   logic signed [HIST_W-1:0]   yh_ff [CHANNELS][2];

   req_type                    req_ff;
   logic                       in_range_ff;
   logic signed [SAMPLE_W-1:0] x1_ff, x2_ff;
   logic signed [HIST_W-1:0]   s1_ff, s2_ff, y1_ff, y2_ff;
   logic signed [HIST_W-1:0]   s_ff, y_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic                       pvalid_ff, psub_ff;
   logic signed [ACC_W-1:0]    acc_ff;
   rsp_type                    rsp_ff;

   logic                       req_in_range;
   logic [CH_IDX_W-1:0]        req_idx, idx;
   logic signed [COEF_W-1:0]   coef_sel;
   logic signed [OPND_W-1:0]   opnd_sel;
   logic                       sub_sel;
   logic signed [ACC_W-1:0]    prod_ext, rnd_sum, rnd_shift;
   logic signed [HIST_W-1:0]   rnd_val;

   assign req_in_range = ({1'b0, req_data.channel} < (CH_W + 1)'(CHANNELS));
   assign req_idx      = req_data.channel[CH_IDX_W-1:0];
   assign idx          = req_ff.channel[CH_IDX_W-1:0];
   assign status.bypass = req_ff.func || !in_range_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) coef_ff[i] <= REG_RESET[i];
      end else if (csr_we) begin
         coef_ff[csr_index] <= csr_wdata;
      end
   end

   // Request latch and history read for the selected channel.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff      <= req_data;
         in_range_ff <= req_in_range;
         if (req_in_range) begin
            x1_ff <= xh_ff[req_idx][0];
            x2_ff <= xh_ff[req_idx][1];
            s1_ff <= sh_ff[req_idx][0];
            s2_ff <= sh_ff[req_idx][1];
            y1_ff <= yh_ff[req_idx][0];
            y2_ff <= yh_ff[req_idx][1];
         end else begin
            x1_ff <= '0;
            x2_ff <= '0;
            s1_ff <= '0;
            s2_ff <= '0;
            y1_ff <= '0;
            y2_ff <= '0;
         end
      end
   end

   // Tap selection. The high-pass middle tap uses twice the previous shelf
   // output against the gain, so the numerator needs only one coefficient.
   always_comb begin
      coef_sel = coef_ff[REG_SHELF_B0];
      opnd_sel = '0;
      sub_sel  = 1'b0;
      if (!cmd.hp_stage) begin
         unique case (cmd.step)
            3'd0: begin
               coef_sel = coef_ff[REG_SHELF_B0];
               opnd_sel = OPND_W'(req_ff.sample);
            end
            3'd1: begin
               coef_sel = coef_ff[REG_SHELF_B1];
               opnd_sel = OPND_W'(x1_ff);
            end
            3'd2: begin
               coef_sel = coef_ff[REG_SHELF_B2];
               opnd_sel = OPND_W'(x2_ff);
            end
            3'd3: begin
               coef_sel = coef_ff[REG_SHELF_A1];
               opnd_sel = OPND_W'(s1_ff);
               sub_sel  = 1'b1;
            end
            3'd4: begin
               coef_sel = coef_ff[REG_SHELF_A2];
               opnd_sel = OPND_W'(s2_ff);
               sub_sel  = 1'b1;
            end
            default: begin
               coef_sel = coef_ff[REG_SHELF_B0];
               opnd_sel = '0;
            end
         endcase
      end else begin
         unique case (cmd.step)
            3'd0: begin
               coef_sel = coef_ff[REG_HIGHPASS_GAIN];
               opnd_sel = OPND_W'(s_ff);
            end
            3'd1: begin
               coef_sel = coef_ff[REG_HIGHPASS_GAIN];
               opnd_sel = {s1_ff, 1'b0};
               sub_sel  = 1'b1;
            end
            3'd2: begin
               coef_sel = coef_ff[REG_HIGHPASS_GAIN];
               opnd_sel = OPND_W'(s2_ff);
            end
            3'd3: begin
               coef_sel = coef_ff[REG_HIGHPASS_A1];
               opnd_sel = OPND_W'(y1_ff);
               sub_sel  = 1'b1;
            end
            3'd4: begin
               coef_sel = coef_ff[REG_HIGHPASS_A2];
               opnd_sel = OPND_W'(y2_ff);
               sub_sel  = 1'b1;
            end
            default: begin
               coef_sel = coef_ff[REG_HIGHPASS_GAIN];
               opnd_sel = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= coef_sel * opnd_sel;
      psub_ff <= sub_sel;
   end

   assign prod_ext = {{(ACC_W - PROD_W){prod_ff[PROD_W-1]}}, prod_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         pvalid_ff <= 1'b0;
      end else begin
         pvalid_ff <= cmd.mul_en;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.acc_clr) begin
         acc_ff <= '0;
      end else if (pvalid_ff) begin
         acc_ff <= psub_ff ? acc_ff - prod_ext : acc_ff + prod_ext;
      end
   end

   // Round half up to the Q1.23 grid, then saturate to 28 bits.
   always_comb begin
      rnd_sum   = acc_ff + (ACC_W'(1) <<< (FRAC_DROP - 1));
      rnd_shift = rnd_sum >>> FRAC_DROP;
      if (rnd_shift > ACC_W'((64'sd1 <<< (HIST_W - 1)) - 64'sd1)) begin
         rnd_val = {1'b0, {(HIST_W - 1){1'b1}}};
      end else if (rnd_shift < -(64'sd1 <<< (HIST_W - 1))) begin
         rnd_val = {1'b1, {(HIST_W - 1){1'b0}}};
      end else begin
         rnd_val = rnd_shift[HIST_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.shelf_rnd) s_ff <= rnd_val;
      if (cmd.hp_rnd) y_ff <= rnd_val;
   end

   // Delay state: a flush zeroes the channel, a filtered word shifts it.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            for (int t = 0; t < 2; t++) begin
               xh_ff[c][t] <= '0;
               sh_ff[c][t] <= '0;
               yh_ff[c][t] <= '0;
            end
         end
      end else if (cmd.retire && in_range_ff) begin
         if (req_ff.func) begin
            xh_ff[idx][0] <= '0;
            xh_ff[idx][1] <= '0;
            sh_ff[idx][0] <= '0;
            sh_ff[idx][1] <= '0;
            yh_ff[idx][0] <= '0;
            yh_ff[idx][1] <= '0;
         end else begin
            xh_ff[idx][0] <= req_ff.sample;
            xh_ff[idx][1] <= x1_ff;
            sh_ff[idx][0] <= s_ff;
            sh_ff[idx][1] <= s1_ff;
            yh_ff[idx][0] <= y_ff;
            yh_ff[idx][1] <= y1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.retire) begin
         rsp_ff.out_channel <= req_ff.channel;
         rsp_ff.weighted    <= status.bypass ? '0 : y_ff;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

FILE: rtl/k_weighting_filter.sv
// K-weighting filter: high-shelf then high-pass biquad per channel word.
// A filtered sample passes through both stages on one shared 32x29 multiplier,
// five products per stage; a flush or an out-of-range channel skips the products.
// Only one word is in flight: a new word is accepted once the last has retired.
// Synchronous active-high reset restores the 48 kHz coefficients and clears
// all channel state at once; the block is ready in the cycle after reset.
`include "k_weighting_filter_macros.svh"
module k_weighting_filter
   import kwf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [REG_IDX_W-1:0] csr_index,
   input  logic [COEF_W-1:0]    csr_wdata
);

   kwf_cmd_type    cmd;
   kwf_status_type status;

   kwf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   kwf_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status)
   );

   // Only one word is in flight, so an accepted word closes the input side.
   `KWF_ASSERT_NEXT(a_single_word, req_valid && !req_stall, req_stall)
   // A retired word is always presented on the result side.
   `KWF_ASSERT_NEXT(a_retire_shows, cmd.retire, rsp_valid)
   // Flushes and out-of-range channels return a zero result.
   `KWF_ASSERT_NEXT(a_bypass_zero, cmd.retire && status.bypass, rsp_data.weighted == '0)
   // Multiplier steps never overlap with a retiring word.
   `KWF_ASSERT_NOW(a_no_mac_on_retire, cmd.retire, !cmd.mul_en)

endmodule
